// ===== design/xcsfp_pkg.sv =====
// xcsfp_pkg: shared types and constants for the xor checked status frame parser
// used by every module of the block; depends on nothing
package xcsfp_pkg;

   localparam int FRAME_BYTES = 6;
   localparam int POS_W       = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   // frame byte positions
   localparam logic [POS_W-1:0] POS_HEAD   = 3'd0;
   localparam logic [POS_W-1:0] POS_OPCODE = 3'd1;
   localparam logic [POS_W-1:0] POS_DATA_H = 3'd2;
   localparam logic [POS_W-1:0] POS_DATA_L = 3'd3;
   localparam logic [POS_W-1:0] POS_CHECK  = 3'd4;

   // status word decode, bits of the high and low byte
   localparam logic [7:0] STAGE_MASK   = 8'h70;
   localparam int         STAGE_SHIFT  = 4;
   localparam logic [7:0] MODE_MASK    = 8'h0F;
   localparam logic [7:0] GAUGE_MASK   = 8'h20;
   localparam logic [7:0] TURBO_MASK   = 8'h10;
   localparam logic [7:0] MECH_MASK    = 8'h08;
   localparam logic [7:0] VENT_2_MASK  = 8'h04;
   localparam logic [7:0] VENT_1_MASK  = 8'h02;
   localparam logic [7:0] VALVE_1_MASK = 8'h01;

   localparam logic [7:0] STATUS_OPCODE_RESET = 8'd17;

   typedef enum logic [2:0] {
      KIND_BAD_FRAME = 3'd0,
      KIND_BAD_CHECK = 3'd1,
      KIND_STATUS    = 3'd2,
      KIND_PRESSURE  = 3'd3,
      KIND_CLEAR     = 3'd4,
      KIND_WARNING   = 3'd5,
      KIND_UNKNOWN   = 3'd6
   } frame_kind_type;

   typedef enum logic [2:0] {
      REG_HEAD     = 3'd0,
      REG_TAIL     = 3'd1,
      REG_STATUS   = 3'd2,
      REG_PRESSURE = 3'd3,
      REG_CLEAR    = 3'd4,
      REG_WARNING  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [7:0] head_byte;
      logic [7:0] tail_byte;
      logic [7:0] status_opcode;
      logic [7:0] pressure_opcode;
      logic [7:0] clear_opcode;
      logic [7:0] warning_opcode;
   } csr_regs_type;

   // completed frame handed from the assembler to the result stage
   typedef struct packed {
      logic        head_ok;
      logic        check_ok;
      logic [7:0]  opcode;
      logic [15:0] data_word;
      logic [7:0]  tail;
   } frame_type;

endpackage

// ===== design/xcsfp_if.sv =====
// xcsfp_req_if and xcsfp_rsp_if: valid/ready channels of the frame parser
// depends on nothing; payload widths follow the byte and result fields
interface xcsfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_read;

   modport source (output valid, output rx_byte, output end_of_read, input ready);
   modport sink   (input valid, input rx_byte, input end_of_read, output ready);
endinterface

interface xcsfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  frame_kind;
   logic        status_changed;
   logic [2:0]  stage;
   logic [3:0]  mode_nibble;
   logic        gauge_power_on;
   logic        turbo_pump_on;
   logic        mech_pump_on;
   logic        vent_two_open;
   logic        vent_one_open;
   logic        valve_one_open;
   logic [15:0] data_word;

   modport source (
      output valid, output frame_kind, output status_changed, output stage,
      output mode_nibble, output gauge_power_on, output turbo_pump_on,
      output mech_pump_on, output vent_two_open, output vent_one_open,
      output valve_one_open, output data_word, input ready
   );
   modport sink (
      input valid, input frame_kind, input status_changed, input stage,
      input mode_nibble, input gauge_power_on, input turbo_pump_on,
      input mech_pump_on, input vent_two_open, input vent_one_open,
      input valve_one_open, input data_word, output ready
   );
endinterface

// ===== design/xor_checked_status_frame_parser.sv =====
// xor_checked_status_frame_parser: top level of the status frame parser
// depends on xcsfp_pkg, xcsfp_if, xcsfp_csr, xcsfp_assembler, xcsfp_result
//
//   channel   direction  handshake          carries
//   req_bus   in         valid/ready        rx_byte, end_of_read
//   rsp_bus   out        valid/ready        frame kind, status decode, data word
//   csr_*     in/out     apb psel/penable   head, tail and four opcode registers
//
// one received byte per cycle unless a sixth byte waits; a beat is registered
// in the input register, and the frame's sixth byte moves on into the result register
// sync active-high reset clears position, check state, status word and valids
// only a sixth byte waits on a full result register; other bytes always drain
// the result register is a full output stage, so bytes keep flowing while a
// finished frame waits to be taken
module xor_checked_status_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   xcsfp_req_if.sink                         req_bus,
   xcsfp_rsp_if.source                       rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [xcsfp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [xcsfp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [xcsfp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

   xcsfp_pkg::csr_regs_type regs;
   xcsfp_pkg::frame_type    frame;
   logic                    frame_valid;
   logic                    res_ready;

   // register bank
   xcsfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   // byte position, head check and xor accumulation
   xcsfp_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .regs        (regs),
      .res_ready   (res_ready),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   // classification, status word and result register
   xcsfp_result u_result (
      .clock       (clock),
      .reset       (reset),
      .regs        (regs),
      .frame_valid (frame_valid),
      .frame       (frame),
      .res_ready   (res_ready),
      .rsp_bus     (rsp_bus)
   );

   // a completed frame that is taken shows up as a result beat next cycle
   a_frame_to_result: assert property (@(posedge clock) disable iff (reset)
      frame_valid && res_ready |=> rsp_bus.valid)
      else $error("completed frame produced no result beat");

   // a bad head always classes the frame as bad, whatever else is wrong
   a_bad_head_kind: assert property (@(posedge clock) disable iff (reset)
      frame_valid && res_ready && !frame.head_ok |=>
         rsp_bus.frame_kind == xcsfp_pkg::KIND_BAD_FRAME)
      else $error("bad head not reported as bad frame");

   // the changed flag only rides on status frames
   a_changed_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status_changed |->
         rsp_bus.frame_kind == xcsfp_pkg::KIND_STATUS)
      else $error("status changed flagged on non-status frame");

   // the decoded fields of a changed status word match its bits 14:8 and 5:0
   a_changed_new_word: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status_changed |->
         ({rsp_bus.stage, rsp_bus.mode_nibble} == rsp_bus.data_word[14:8]) &&
         ({rsp_bus.gauge_power_on, rsp_bus.turbo_pump_on, rsp_bus.mech_pump_on,
           rsp_bus.vent_two_open, rsp_bus.vent_one_open, rsp_bus.valve_one_open} ==
          rsp_bus.data_word[5:0]))
      else $error("status change bookkeeping broken");

endmodule

// ===== design/xcsfp_csr.sv =====
// xcsfp_csr: apb-style register bank holding head, tail and opcode registers
// depends on xcsfp_pkg
module xcsfp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [xcsfp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [xcsfp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [xcsfp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready,
   output xcsfp_pkg::csr_regs_type           regs
);

   xcsfp_pkg::csr_regs_type regs_ff;
   xcsfp_pkg::csr_regs_type regs_in;
   logic [2:0]              index;
   logic [7:0]              wdata;
   logic [7:0]              rdata;
   logic                    wr_en;

   assign index      = csr_paddr[4:2];
   assign wdata      = csr_pwdata[7:0];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign regs       = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         case (index)
            xcsfp_pkg::REG_HEAD:     regs_in.head_byte       = wdata;
            xcsfp_pkg::REG_TAIL:     regs_in.tail_byte       = wdata;
            xcsfp_pkg::REG_STATUS:   regs_in.status_opcode   = wdata;
            xcsfp_pkg::REG_PRESSURE: regs_in.pressure_opcode = wdata;
            xcsfp_pkg::REG_CLEAR:    regs_in.clear_opcode    = wdata;
            xcsfp_pkg::REG_WARNING:  regs_in.warning_opcode  = wdata;
            default:                 regs_in = regs_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         xcsfp_pkg::REG_HEAD:     rdata = regs_ff.head_byte;
         xcsfp_pkg::REG_TAIL:     rdata = regs_ff.tail_byte;
         xcsfp_pkg::REG_STATUS:   rdata = regs_ff.status_opcode;
         xcsfp_pkg::REG_PRESSURE: rdata = regs_ff.pressure_opcode;
         xcsfp_pkg::REG_CLEAR:    rdata = regs_ff.clear_opcode;
         xcsfp_pkg::REG_WARNING:  rdata = regs_ff.warning_opcode;
         default:                 rdata = 8'd0;
      endcase
   end

   assign csr_prdata = {{(xcsfp_pkg::CSR_DATA_W-8){1'b0}}, rdata};

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{status_opcode: xcsfp_pkg::STATUS_OPCODE_RESET, default: 8'd0};
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ===== design/xcsfp_assembler.sv =====
// xcsfp_assembler: input register, byte position counter and running xor check
// depends on xcsfp_pkg and xcsfp_req_if
module xcsfp_assembler (
   input  logic                     clock,
   input  logic                     reset,
   xcsfp_req_if.sink                req_bus,
   input  xcsfp_pkg::csr_regs_type  regs,
   input  logic                     res_ready,
   output logic                     frame_valid,
   output xcsfp_pkg::frame_type     frame
);

   logic                          in_valid_ff, in_valid_in;
   logic [7:0]                    in_byte_ff, in_byte_in;
   logic                          in_eor_ff, in_eor_in;
   logic [xcsfp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                          head_ok_ff, head_ok_in;
   logic [7:0]                    opcode_ff, opcode_in;
   logic [7:0]                    data_high_ff, data_high_in;
   logic [7:0]                    data_low_ff, data_low_in;
   logic [7:0]                    check_ff, check_in;
   logic                          check_ok_ff, check_ok_in;
   logic                          is_last;
   logic                          advance;
   logic                          take;

   assign is_last     = in_valid_ff && (pos_ff >= xcsfp_pkg::LAST_POS);
   assign advance     = in_valid_ff && (!is_last || res_ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take        = req_bus.valid && req_bus.ready;

   assign frame_valid     = is_last;
   assign frame.head_ok   = head_ok_ff;
   assign frame.check_ok  = check_ok_ff;
   assign frame.opcode    = opcode_ff;
   assign frame.data_word = {data_high_ff, data_low_ff};
   assign frame.tail      = in_byte_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eor_in   = in_eor_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.rx_byte;
         in_eor_in   = req_bus.end_of_read;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      head_ok_in   = head_ok_ff;
      opcode_in    = opcode_ff;
      data_high_in = data_high_ff;
      data_low_in  = data_low_ff;
      check_in     = check_ff;
      check_ok_in  = check_ok_ff;
      if (advance) begin
         case (pos_ff)
            xcsfp_pkg::POS_HEAD: begin
               head_ok_in = (in_byte_ff == regs.head_byte);
               check_in   = 8'd0;
            end
            xcsfp_pkg::POS_OPCODE: begin
               opcode_in = in_byte_ff;
               check_in  = in_byte_ff;
            end
            xcsfp_pkg::POS_DATA_H: begin
               data_high_in = in_byte_ff;
               check_in     = check_ff ^ in_byte_ff;
            end
            xcsfp_pkg::POS_DATA_L: begin
               data_low_in = in_byte_ff;
               check_in    = check_ff ^ in_byte_ff;
            end
            xcsfp_pkg::POS_CHECK: begin
               check_ok_in = (check_ff == in_byte_ff);
            end
            default: begin
               check_ok_in = check_ok_ff;
            end
         endcase
         if (is_last || in_eor_ff) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         head_ok_ff   <= 1'b0;
         opcode_ff    <= 8'd0;
         data_high_ff <= 8'd0;
         data_low_ff  <= 8'd0;
         check_ff     <= 8'd0;
         check_ok_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         head_ok_ff   <= head_ok_in;
         opcode_ff    <= opcode_in;
         data_high_ff <= data_high_in;
         data_low_ff  <= data_low_in;
         check_ff     <= check_in;
         check_ok_ff  <= check_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eor_ff  <= in_eor_in;
   end

endmodule

// ===== design/xcsfp_result.sv =====
// xcsfp_result: frame classification, stored status word and result register
// depends on xcsfp_pkg and xcsfp_rsp_if
module xcsfp_result (
   input  logic                     clock,
   input  logic                     reset,
   input  xcsfp_pkg::csr_regs_type  regs,
   input  logic                     frame_valid,
   input  xcsfp_pkg::frame_type     frame,
   output logic                     res_ready,
   xcsfp_rsp_if.source              rsp_bus
);

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [15:0]                status_ff, status_in;
   xcsfp_pkg::frame_kind_type  kind_ff, kind;
   logic                       changed_ff, changed;
   logic [15:0]                word_ff;
   logic [15:0]                shown_ff;
   logic                       fire;
   logic [7:0]                 hi;
   logic [7:0]                 lo;

   assign res_ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire      = frame_valid && res_ready;

   always_comb begin
      changed   = 1'b0;
      status_in = status_ff;
      if (!frame.head_ok || (frame.tail != regs.tail_byte)) begin
         kind = xcsfp_pkg::KIND_BAD_FRAME;
      end else if (!frame.check_ok) begin
         kind = xcsfp_pkg::KIND_BAD_CHECK;
      end else if (frame.opcode == regs.status_opcode) begin
         kind = xcsfp_pkg::KIND_STATUS;
         if (frame.data_word != status_ff) begin
            status_in = frame.data_word;
            changed   = 1'b1;
         end
      end else if (frame.opcode == regs.pressure_opcode) begin
         kind = xcsfp_pkg::KIND_PRESSURE;
      end else if (frame.opcode == regs.clear_opcode) begin
         kind = xcsfp_pkg::KIND_CLEAR;
      end else if (frame.opcode == regs.warning_opcode) begin
         kind = xcsfp_pkg::KIND_WARNING;
      end else begin
         kind = xcsfp_pkg::KIND_UNKNOWN;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         status_ff    <= 16'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            status_ff <= status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff    <= kind;
         changed_ff <= changed;
         word_ff    <= frame.data_word;
         shown_ff   <= status_in;
      end
   end

   assign hi = shown_ff[15:8];
   assign lo = shown_ff[7:0];

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.frame_kind     = kind_ff;
   assign rsp_bus.status_changed = changed_ff;
   assign rsp_bus.stage          = 3'((hi & xcsfp_pkg::STAGE_MASK) >> xcsfp_pkg::STAGE_SHIFT);
   assign rsp_bus.mode_nibble    = 4'(hi & xcsfp_pkg::MODE_MASK);
   assign rsp_bus.gauge_power_on = |(lo & xcsfp_pkg::GAUGE_MASK);
   assign rsp_bus.turbo_pump_on  = |(lo & xcsfp_pkg::TURBO_MASK);
   assign rsp_bus.mech_pump_on   = |(lo & xcsfp_pkg::MECH_MASK);
   assign rsp_bus.vent_two_open  = |(lo & xcsfp_pkg::VENT_2_MASK);
   assign rsp_bus.vent_one_open  = |(lo & xcsfp_pkg::VENT_1_MASK);
   assign rsp_bus.valve_one_open = |(lo & xcsfp_pkg::VALVE_1_MASK);
   assign rsp_bus.data_word      = word_ff;

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for xor_checked_status_frame_parser, driving bytes,
// registers and a randomly stalled result side and checking every frame report
// depends on xcsfp_pkg, xcsfp_req_if / xcsfp_rsp_if and the parser top level
module testbench;
   import xcsfp_pkg::*;

   localparam int IDLE_PERCENT     = 13;    // chance of a bubble on either side
   localparam int DRAIN_CYCLES     = 8;     // input register plus result register, with margin
   localparam int HOLD_OFF_CYCLES  = 80;    // long result-side stall for back pressure
   localparam int IDLE_LIMIT       = 2000;  // cycles without any beat before giving up
   localparam int REG_COUNT        = 6;
   localparam int REG_STRIDE       = 4;
   localparam int FRAMES_PER_PHASE = 30;
   localparam int RANDOM_PHASES    = 6;

   // shapes of generated traffic
   typedef enum int {
      SHAPE_STATUS,
      SHAPE_STATUS_SAME,
      SHAPE_PRESSURE,
      SHAPE_CLEAR,
      SHAPE_WARNING,
      SHAPE_UNKNOWN,
      SHAPE_BAD_CHECK,
      SHAPE_BAD_HEAD,
      SHAPE_BAD_TAIL,
      SHAPE_NOISE,
      SHAPE_CUT
   } frame_shape_t;

   // one predicted frame report
   typedef struct packed {
      frame_kind_type kind;
      logic           changed;
      logic [2:0]     stage;
      logic [3:0]     mode;
      logic           gauge;
      logic           turbo;
      logic           mech;
      logic           vent_two;
      logic           vent_one;
      logic           valve_one;
      logic [15:0]    word;
   } frame_report_t;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   xcsfp_req_if req_bus ();
   xcsfp_rsp_if rsp_bus ();

   xor_checked_status_frame_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // parser shadow: register copy plus the frame assembly state
   csr_regs_type    model_regs;
   logic [POS_W-1:0] frame_pos;
   logic            held_head_ok;
   logic [7:0]      held_opcode;
   logic [7:0]      held_high;
   logic [7:0]      held_low;
   logic [7:0]      xor_acc;
   logic            held_check_ok;
   logic [15:0]     status_word;

   frame_report_t pending_frames[$];

   // run flags shared by the stimulus and the two bus sides
   bit sender_steady    = 1'b0;
   bit receiver_steady  = 1'b0;
   bit hold_off_pending = 1'b0;

   int failures        = 0;
   int bytes_sent      = 0;
   int frames_checked  = 0;
   int settings_applied = 0;
   int quiet_cycles    = 0;
   int kind_count [7];

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   // advance the shadow parser by one accepted byte; returns 1 when a frame completes
   function automatic bit parse_rx_byte(input logic [7:0] rx, input logic last_of_read,
                                        output frame_report_t report);
      bit          complete;
      logic [15:0] word;
      logic [7:0]  hi;
      logic [7:0]  lo;
      complete = 1'b0;
      report   = '0;
      if (frame_pos >= LAST_POS) begin
         // tail byte: classify with the registers as they are now
         word = {held_high, held_low};
         if (!held_head_ok || rx != model_regs.tail_byte) begin
            report.kind = KIND_BAD_FRAME;
         end else if (!held_check_ok) begin
            report.kind = KIND_BAD_CHECK;
         end else if (held_opcode == model_regs.status_opcode) begin
            report.kind = KIND_STATUS;
            if (word != status_word) begin
               status_word    = word;
               report.changed = 1'b1;
            end
         end else if (held_opcode == model_regs.pressure_opcode) begin
            report.kind = KIND_PRESSURE;
         end else if (held_opcode == model_regs.clear_opcode) begin
            report.kind = KIND_CLEAR;
         end else if (held_opcode == model_regs.warning_opcode) begin
            report.kind = KIND_WARNING;
         end else begin
            report.kind = KIND_UNKNOWN;
         end
         // decode always shows the stored word, after any update above
         hi = status_word[15:8];
         lo = status_word[7:0];
         report.stage     = 3'((hi & STAGE_MASK) >> STAGE_SHIFT);
         report.mode      = 4'(hi & MODE_MASK);
         report.gauge     = |(lo & GAUGE_MASK);
         report.turbo     = |(lo & TURBO_MASK);
         report.mech      = |(lo & MECH_MASK);
         report.vent_two  = |(lo & VENT_2_MASK);
         report.vent_one  = |(lo & VENT_1_MASK);
         report.valve_one = |(lo & VALVE_1_MASK);
         report.word      = word;
         frame_pos = POS_HEAD;
         complete  = 1'b1;
      end else begin
         case (frame_pos)
            POS_HEAD: begin
               held_head_ok = (rx == model_regs.head_byte);
               xor_acc      = 8'h00;
            end
            POS_OPCODE: begin
               held_opcode = rx;
               xor_acc     = rx;
            end
            POS_DATA_H: begin
               held_high = rx;
               xor_acc   = xor_acc ^ rx;
            end
            POS_DATA_L: begin
               held_low = rx;
               xor_acc  = xor_acc ^ rx;
            end
            default: begin
               held_check_ok = (xor_acc == rx);
            end
         endcase
         frame_pos = frame_pos + 3'd1;
      end
      if (last_of_read) frame_pos = POS_HEAD;
      return complete;
   endfunction

   // one byte beat; valid is left high after acceptance for the next caller
   task automatic send_byte(input logic [7:0] value, input logic last_of_read);
      frame_report_t report;
      while (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.rx_byte     <= value;
      req_bus.end_of_read <= last_of_read;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      bytes_sent++;
      if (parse_rx_byte(value, last_of_read, report)) pending_frames.push_back(report);
   endtask

   task automatic send_frame_bytes(input logic [7:0] head, input logic [7:0] op,
                                   input logic [7:0] hi, input logic [7:0] lo,
                                   input logic [7:0] chk, input logic [7:0] tail,
                                   input logic last_of_read);
      send_byte(head, 1'b0);
      send_byte(op, 1'b0);
      send_byte(hi, 1'b0);
      send_byte(lo, 1'b0);
      send_byte(chk, 1'b0);
      send_byte(tail, last_of_read);
   endtask

   // drop valid, let all reports come back, then let the pipeline settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // setup then access phase; psel stays up so transfers can run back to back
   task automatic apb_transfer(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
   endtask

   // write all six registers with read-back, plus one write to an unmapped index
   task automatic program_registers(input csr_regs_type regs);
      logic [7:0]            vals [REG_COUNT];
      logic [CSR_DATA_W-1:0] rd;
      reg_index_type         idx;
      vals = '{regs.head_byte, regs.tail_byte, regs.status_opcode,
               regs.pressure_opcode, regs.clear_opcode, regs.warning_opcode};
      for (int i = 0; i < REG_COUNT; i++) begin
         idx = reg_index_type'(i);
         apb_transfer(1'b1, CSR_ADDR_W'(i * REG_STRIDE), CSR_DATA_W'(vals[i]), rd);
         apb_transfer(1'b0, CSR_ADDR_W'(i * REG_STRIDE), '0, rd);
         check_field($sformatf("%s readback", idx.name()), CSR_DATA_W'(vals[i]), rd);
      end
      apb_transfer(1'b1, CSR_ADDR_W'($urandom_range(7, REG_COUNT) * REG_STRIDE),
                   CSR_DATA_W'($urandom), rd);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      model_regs = regs;
      settings_applied++;
   endtask

   function automatic frame_shape_t pick_shape();
      int roll;
      roll = $urandom_range(99);
      if (roll < 18) return SHAPE_STATUS;
      if (roll < 25) return SHAPE_STATUS_SAME;
      if (roll < 37) return SHAPE_PRESSURE;
      if (roll < 47) return SHAPE_CLEAR;
      if (roll < 57) return SHAPE_WARNING;
      if (roll < 67) return SHAPE_UNKNOWN;
      if (roll < 77) return SHAPE_BAD_CHECK;
      if (roll < 85) return SHAPE_BAD_HEAD;
      if (roll < 92) return SHAPE_BAD_TAIL;
      if (roll < 96) return SHAPE_NOISE;
      return SHAPE_CUT;
   endfunction

   // well-formed frame with random content, or a deliberately broken one
   task automatic send_frame(input frame_shape_t shape);
      logic [7:0] head;
      logic [7:0] op;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] chk;
      logic [7:0] tail;
      logic [7:0] fb [6];
      int         cut;
      // finish any partial frame left by noise
      while (frame_pos != POS_HEAD) send_byte(8'($urandom), 1'b0);
      head = model_regs.head_byte;
      tail = model_regs.tail_byte;
      hi   = 8'($urandom);
      lo   = 8'($urandom);
      case (shape)
         SHAPE_STATUS:      op = model_regs.status_opcode;
         SHAPE_STATUS_SAME: begin
            op       = model_regs.status_opcode;
            {hi, lo} = status_word;
         end
         SHAPE_PRESSURE:    op = model_regs.pressure_opcode;
         SHAPE_CLEAR:       op = model_regs.clear_opcode;
         SHAPE_WARNING:     op = model_regs.warning_opcode;
         SHAPE_UNKNOWN: begin
            do op = 8'($urandom);
            while (op == model_regs.status_opcode || op == model_regs.pressure_opcode ||
                   op == model_regs.clear_opcode || op == model_regs.warning_opcode);
         end
         default:           op = 8'($urandom);
      endcase
      chk = op ^ hi ^ lo;
      case (shape)
         SHAPE_BAD_CHECK: chk = chk ^ 8'(1 << $urandom_range(7));
         SHAPE_BAD_HEAD: begin
            head = head ^ 8'($urandom_range(255, 1));
            if ($urandom_range(1) == 1) chk = chk ^ 8'($urandom_range(255, 1));
         end
         SHAPE_BAD_TAIL:  tail = tail ^ 8'($urandom_range(255, 1));
         default: ;
      endcase
      if (shape == SHAPE_NOISE) begin
         repeat ($urandom_range(8, 1)) send_byte(8'($urandom), $urandom_range(3) == 0);
      end else if (shape == SHAPE_CUT) begin
         // partial frame closed by end of read, never reported
         fb  = '{head, op, hi, lo, chk, tail};
         cut = $urandom_range(5, 1);
         for (int i = 0; i < cut; i++) send_byte(fb[i], i == cut - 1);
      end else begin
         send_frame_bytes(head, op, hi, lo, chk, tail, $urandom_range(3) == 0);
      end
   endtask

   task automatic run_frames(input int count);
      repeat (count) send_frame(pick_shape());
   endtask

   // reset values of the registers, word extremes, broken and cut frames
   task automatic test_default_registers();
      logic [7:0] head;
      logic [7:0] op;
      logic [7:0] tail;
      head = model_regs.head_byte;
      op   = model_regs.status_opcode;
      tail = model_regs.tail_byte;
      // all-ones status word, end of read on the tail byte
      send_frame_bytes(head, op, 8'hFF, 8'hFF, op, tail, 1'b1);
      // head and checksum both wrong: still a bad frame
      send_frame_bytes(~head, op, 8'h00, 8'h00, 8'h00, tail, 1'b0);
      // buffer ends after three bytes: dropped
      send_byte(head, 1'b0);
      send_byte(op, 1'b0);
      send_byte(8'h05, 1'b1);
      // single flipped bit in the check byte
      send_frame_bytes(head, op, 8'h00, 8'h00, op ^ 8'h80, tail, 1'b0);
      // status word back to all zeros
      send_frame_bytes(head, op, 8'h00, 8'h00, op, tail, 1'b0);
   endtask

   // head judged with the old head byte, tail and opcode with the new registers
   task automatic test_config_mid_frame();
      csr_regs_type regs;
      wait_idle();
      regs = model_regs;
      regs.head_byte = 8'hA5;
      regs.tail_byte = 8'h5A;
      program_registers(regs);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h81, 1'b0);
      wait_idle();
      regs.head_byte     = 8'h3C;
      regs.tail_byte     = 8'hC3;
      regs.status_opcode = 8'h42;
      program_registers(regs);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h42 ^ 8'h81 ^ 8'h7E, 1'b0);
      send_byte(8'hC3, 1'b0);
   endtask

   // several register settings: all zeros, all ones, random, forced overlaps
   task automatic test_random_traffic();
      csr_regs_type regs;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: regs = '0;
            1: regs = '1;
            default: regs = csr_regs_type'(48'({$urandom, $urandom}));
         endcase
         if (phase == 3) regs.clear_opcode = regs.pressure_opcode;
         if (phase == 4) regs.tail_byte = regs.head_byte;
         wait_idle();
         program_registers(regs);
         run_frames(FRAMES_PER_PHASE);
      end
   endtask

   // no bubbles on either side for a long stretch
   task automatic test_back_to_back();
      sender_steady   = 1'b1;
      receiver_steady = 1'b1;
      run_frames(FRAMES_PER_PHASE);
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   // result side holds off while bytes keep coming, so the input must stall
   task automatic test_receiver_hold_off();
      sender_steady    = 1'b1;
      hold_off_pending = 1'b1;
      run_frames(25);
      sender_steady    = 1'b0;
   endtask

   // result side: random ready, optional long hold-off counted here
   initial begin : result_receiver
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= receiver_steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // each report beat against the oldest prediction
   always @(posedge clock) begin : result_checker
      frame_report_t want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_frames.size() == 0) begin
            $error("frame report beat with no frame pending");
            failures++;
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            kind_count[want.kind]++;
            check_field("frame_kind", want.kind, rsp_bus.frame_kind);
            check_field("status_changed", want.changed, rsp_bus.status_changed);
            check_field("stage", want.stage, rsp_bus.stage);
            check_field("mode_nibble", want.mode, rsp_bus.mode_nibble);
            check_field("gauge_power_on", want.gauge, rsp_bus.gauge_power_on);
            check_field("turbo_pump_on", want.turbo, rsp_bus.turbo_pump_on);
            check_field("mech_pump_on", want.mech, rsp_bus.mech_pump_on);
            check_field("vent_two_open", want.vent_two, rsp_bus.vent_two_open);
            check_field("vent_one_open", want.vent_one, rsp_bus.vent_one_open);
            check_field("valve_one_open", want.valve_one, rsp_bus.valve_one_open);
            check_field("data_word", want.word, rsp_bus.data_word);
         end
      end
   end

   // give up when nothing moves on any port for too long
   always @(posedge clock) begin : stall_watchdog
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.rx_byte     = 8'h00;
      req_bus.end_of_read = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      // shadow state matches the block after reset
      model_regs               = '0;
      model_regs.status_opcode = STATUS_OPCODE_RESET;
      frame_pos     = POS_HEAD;
      held_head_ok  = 1'b0;
      held_opcode   = 8'h00;
      held_high     = 8'h00;
      held_low      = 8'h00;
      xor_acc       = 8'h00;
      held_check_ok = 1'b0;
      status_word   = 16'h0000;
      foreach (kind_count[k]) kind_count[k] = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_registers();
      test_config_mid_frame();
      test_random_traffic();
      test_back_to_back();
      test_receiver_hold_off();
      wait_idle();

      $display("covered %0d bytes and %0d frame reports over %0d register settings,",
               bytes_sent, frames_checked, settings_applied);
      $display("  kinds bad/check/status/pressure/clear/warning/unknown: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
               kind_count[0], kind_count[1], kind_count[2], kind_count[3],
               kind_count[4], kind_count[5], kind_count[6]);
      if (failures == 0 && pending_frames.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
